>>> rtl/rrsbs_pkg.sv
// ----------------------------------------------------------------------------
// rrsbs_pkg
// Types, codes and helpers shared by the round robin batch scheduler.
// ----------------------------------------------------------------------------
package rrsbs_pkg;

   typedef enum logic [2:0] {
      MODE_ENQUEUE  = 3'd0,
      MODE_SCHEDULE = 3'd1,
      MODE_COMPLETE = 3'd2,
      MODE_PAUSE    = 3'd3,
      MODE_RESUME   = 3'd4,
      MODE_CANCEL   = 3'd5,
      MODE_QUERY    = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      PH_QUEUED    = 3'd0,
      PH_DECODING  = 3'd1,
      PH_PAUSED    = 3'd2,
      PH_FINISHED  = 3'd3,
      PH_CANCELLED = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_LIMIT    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_PREFILL = 2'd0,
      KIND_DECODE  = 2'd1,
      KIND_NONE    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_LOOKUP,
      CS_COUNT,
      CS_EMIT,
      CS_SINGLE
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] seq_id;
      logic [31:0] prompt_len;
      logic [31:0] token_cap;
      logic [31:0] new_tokens;
      logic        terminal;
      logic [7:0]  max_sequences;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_id;
      logic [2:0]  phase;
      logic [1:0]  flags;
      logic [31:0] out_prompt;
      logic [31:0] out_limit;
      logic [31:0] gen_total;
      logic [1:0]  work_kind;
      logic [31:0] token_position;
      logic [5:0]  slot;
      logic [63:0] generation;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] prompt;
      logic [31:0] limit;
      logic [31:0] generated;
      logic [2:0]  phase;
      logic [2:0]  saved_phase;
      logic        running;
      logic        kill_req;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic idle;
      logic load;
      logic set_found;
      logic lookup_inc;
      logic count_step;
      logic sched_start;
      logic emit_step;
      logic scan_skip;
      logic single_out;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_sched;
      logic sched_quick;
      logic match;
      logic lookup_end;
      logic count_done;
      logic cnt_zero;
      logic gen_max;
      logic runnable;
      logic emit_last;
      logic out_free;
   } dp_status_type;

   function automatic rsp_type blank_rsp(input status_type st, input logic [31:0] id);
      rsp_type r;
      r           = '0;
      r.status    = st;
      r.out_id    = id;
      r.work_kind = KIND_NONE;
      r.last      = 1'b1;
      return r;
   endfunction

endpackage

>>> rtl/round_robin_sequence_batch_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_sequence_batch_scheduler
// Sequence table with round robin batch selection.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_data (req_type)
//   rsp      out        rsp_valid / rsp_stall   rsp_data (rsp_type)
//
// One operation at a time. A non-schedule operation finds its entry by an id lookup
// that reads one entry per cycle from the start of the table up to the match (all n
// entries when the id is absent), then presents its result once the output is free.
// A schedule over n entries makes a count pass and an emit pass through the table's
// single registered read port; the emit pass holds while the result is stalled.
// Synchronous reset empties the table; entry contents are not cleared.
// A stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module round_robin_sequence_batch_scheduler
   import rrsbs_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   rrsbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrsbs_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign req_stall = reset || !cmd.idle;

endmodule

>>> rtl/rrsbs_ctrl.sv
// ----------------------------------------------------------------------------
// rrsbs_ctrl
// Sequencer: lookup by id, round robin count pass, emit pass, result.
// ----------------------------------------------------------------------------
module rrsbs_ctrl
   import rrsbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               if (stat.is_sched && stat.sched_quick) state_in = CS_SINGLE;
               else if (stat.is_sched)                state_in = CS_COUNT;
               else                                   state_in = CS_LOOKUP;
            end
         end
         CS_LOOKUP: begin
            if (stat.match || stat.lookup_end) state_in = CS_SINGLE;
         end
         CS_COUNT: begin
            if (stat.count_done) begin
               if (stat.cnt_zero || stat.gen_max) state_in = CS_SINGLE;
               else                               state_in = CS_EMIT;
            end
         end
         CS_EMIT: begin
            if (stat.out_free && stat.runnable && stat.emit_last) state_in = CS_IDLE;
         end
         CS_SINGLE: begin
            if (stat.out_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         CS_IDLE: begin
            cmd.idle = 1'b1;
            cmd.load = req_valid;
         end
         CS_LOOKUP: begin
            cmd.set_found  = stat.match;
            cmd.lookup_inc = !stat.match && !stat.lookup_end;
         end
         CS_COUNT: begin
            cmd.count_step  = !stat.count_done;
            cmd.sched_start = stat.count_done && !stat.cnt_zero && !stat.gen_max;
         end
         CS_EMIT: begin
            cmd.emit_step = stat.runnable && stat.out_free;
            cmd.scan_skip = !stat.runnable;
         end
         CS_SINGLE: begin
            cmd.single_out = stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> rtl/rrsbs_dp.sv
// ----------------------------------------------------------------------------
// rrsbs_dp
// Sequence table, scan pointers, operation logic and result register.
// ----------------------------------------------------------------------------
module rrsbs_dp
   import rrsbs_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic          rsp_stall,
   input  ctrl_cmd_type  cmd,
   output dp_status_type stat,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   entry_type tbl [MAX_ENTRIES];

   req_type         req_ff;
   logic [CW-1:0]   idx_ff, off_ff, cnt_ff, s_ff, count_ff;
   logic [IW-1:0]   scan_ff;
   logic            found_ff;
   logic [63:0]     gen_ff;
   rsp_type         rsp_ff;
   logic            rsp_valid_ff;
   entry_type       e_ff;

   entry_type       e;
   logic [CW-1:0]   idx_next, idx_in, lim;
   logic            runnable, out_free;
   rsp_type         sres, eres;
   logic            swr;
   logic [IW-1:0]   swa;
   entry_type       swd;
   logic [31:0]     remaining, gen_sum;
   logic            tbl_we;
   logic [IW-1:0]   tbl_wa;
   entry_type       tbl_wd;

   // e_ff always holds the entry at idx_ff
   assign e        = e_ff;
   assign idx_next = (idx_ff == count_ff - CW'(1)) ? '0 : idx_ff + CW'(1);
   assign lim      = (req_ff.max_sequences >= 8'(count_ff)) ? count_ff
                                                             : CW'(req_ff.max_sequences);
   assign runnable = !e.running && !e.kill_req &&
                     (e.phase == PH_QUEUED || e.phase == PH_DECODING);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat             = '0;
      stat.is_sched    = (req_data.mode == MODE_SCHEDULE);
      stat.sched_quick = (req_data.max_sequences == 8'd0) || (count_ff == '0);
      stat.match       = (idx_ff < count_ff) && (e.id == req_ff.seq_id);
      stat.lookup_end  = (idx_ff == count_ff);
      stat.count_done  = (off_ff == count_ff) || (cnt_ff == lim);
      stat.cnt_zero    = (cnt_ff == '0);
      stat.gen_max     = (gen_ff == '1);
      stat.runnable    = runnable;
      stat.emit_last   = (s_ff + CW'(1) == cnt_ff);
      stat.out_free    = out_free;
   end

   assign remaining = e.limit - e.generated;
   assign gen_sum   = e.generated + req_ff.new_tokens;

   // result and table update of a one-result operation
   always_comb begin
      sres = blank_rsp(ST_INVALID, req_ff.seq_id);
      swr  = 1'b0;
      swa  = idx_ff[IW-1:0];
      swd  = e;
      unique case (req_ff.mode)
         MODE_ENQUEUE: begin
            if (req_ff.seq_id == '0 || req_ff.prompt_len == '0 ||
                req_ff.token_cap == '0 ||
                req_ff.prompt_len > ~req_ff.token_cap || found_ff) begin
               sres.status = ST_INVALID;
            end else if (count_ff == CW'(MAX_ENTRIES)) begin
               sres.status = ST_LIMIT;
            end else begin
               sres.status     = ST_OK;
               swr             = 1'b1;
               swa             = count_ff[IW-1:0];
               swd.id          = req_ff.seq_id;
               swd.prompt      = req_ff.prompt_len;
               swd.limit       = req_ff.token_cap;
               swd.generated   = '0;
               swd.phase       = PH_QUEUED;
               swd.saved_phase = PH_QUEUED;
               swd.running     = 1'b0;
               swd.kill_req    = 1'b0;
            end
         end
         MODE_SCHEDULE: begin
            sres = blank_rsp(ST_INVALID, '0);
            if (req_ff.max_sequences == 8'd0) begin
               sres.status = ST_INVALID;
            end else if (cnt_ff == '0) begin
               sres.status     = ST_OK;
               sres.generation = gen_ff;
            end else begin
               sres.status = ST_OVERFLOW;
            end
         end
         MODE_COMPLETE: begin
            if (!found_ff || !e.running ||
                (req_ff.new_tokens == '0 && !req_ff.terminal)) begin
               sres.status = ST_INVALID;
            end else if (e.kill_req) begin
               sres.status  = ST_OK;
               swr          = 1'b1;
               swd.running  = 1'b0;
               swd.kill_req = 1'b0;
               swd.phase    = PH_CANCELLED;
            end else if (req_ff.new_tokens > remaining) begin
               sres.status = ST_INVALID;
            end else begin
               sres.status   = ST_OK;
               swr           = 1'b1;
               swd.running   = 1'b0;
               swd.generated = gen_sum;
               swd.phase     = (req_ff.terminal || gen_sum == e.limit) ? PH_FINISHED
                                                                       : PH_DECODING;
            end
         end
         MODE_PAUSE: begin
            if (!found_ff || e.running || e.phase == PH_FINISHED ||
                e.phase == PH_CANCELLED) begin
               sres.status = ST_INVALID;
            end else if (e.phase == PH_PAUSED) begin
               sres.status = ST_OK;
            end else begin
               sres.status     = ST_OK;
               swr             = 1'b1;
               swd.saved_phase = e.phase;
               swd.phase       = PH_PAUSED;
            end
         end
         MODE_RESUME: begin
            if (!found_ff || e.phase != PH_PAUSED) begin
               sres.status = ST_INVALID;
            end else begin
               sres.status = ST_OK;
               swr         = 1'b1;
               swd.phase   = e.saved_phase;
            end
         end
         MODE_CANCEL: begin
            if (!found_ff || e.phase == PH_FINISHED) begin
               sres.status = ST_INVALID;
            end else if (e.phase == PH_CANCELLED) begin
               sres.status = ST_OK;
            end else if (e.running) begin
               sres.status  = ST_OK;
               swr          = 1'b1;
               swd.kill_req = 1'b1;
            end else begin
               sres.status = ST_OK;
               swr         = 1'b1;
               swd.phase   = PH_CANCELLED;
            end
         end
         MODE_QUERY: begin
            if (found_ff) begin
               sres.status     = ST_OK;
               sres.phase      = e.phase;
               sres.flags      = {e.kill_req, e.running};
               sres.out_prompt = e.prompt;
               sres.out_limit  = e.limit;
               sres.gen_total  = e.generated;
            end
         end
         default: sres.status = ST_INVALID;
      endcase
   end

   // one work item of a batch
   always_comb begin
      eres                = blank_rsp(ST_OK, e.id);
      eres.work_kind      = (e.phase == PH_QUEUED) ? KIND_PREFILL : KIND_DECODE;
      eres.token_position = e.prompt + e.generated;
      eres.slot           = 6'(s_ff);
      eres.generation     = gen_ff;
      eres.last           = stat.emit_last;
   end

   always_comb begin
      tbl_we = cmd.emit_step || (cmd.single_out && swr);
      tbl_wa = cmd.emit_step ? idx_ff[IW-1:0] : swa;
      tbl_wd = swd;
      if (cmd.emit_step) begin
         tbl_wd         = e;
         tbl_wd.running = 1'b1;
      end
   end

   // next table index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) idx_in = (req_data.mode == MODE_SCHEDULE) ? CW'(scan_ff) : '0;
      if (cmd.lookup_inc) idx_in = idx_ff + CW'(1);
      if (cmd.count_step || cmd.scan_skip || cmd.emit_step) idx_in = idx_next;
      if (cmd.sched_start) idx_in = CW'(scan_ff);
      if (reset) idx_in = '0;
   end

   // table write and registered read at the next index, forwarding a same-cycle write
   always_ff @(posedge clock) begin
      if (tbl_we) tbl[tbl_wa] <= tbl_wd;
      if (tbl_we && tbl_wa == idx_in[IW-1:0]) e_ff <= tbl_wd;
      else                                     e_ff <= tbl[idx_in[IW-1:0]];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.single_out)     rsp_ff <= sres;
      else if (cmd.emit_step) rsp_ff <= eres;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         s_ff         <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.load) begin
            off_ff   <= '0;
            cnt_ff   <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.set_found)  found_ff <= 1'b1;
         if (cmd.count_step) begin
            if (runnable) cnt_ff <= cnt_ff + CW'(1);
            off_ff <= off_ff + CW'(1);
         end
         if (cmd.sched_start) begin
            gen_ff <= gen_ff + 64'd1;
            s_ff   <= '0;
         end
         if (cmd.emit_step) begin
            s_ff <= s_ff + CW'(1);
            if (stat.emit_last) scan_ff <= idx_next[IW-1:0];
         end
         if (cmd.single_out && swr && req_ff.mode == MODE_ENQUEUE) begin
            count_ff <= count_ff + CW'(1);
         end
         // hold a stalled result, drop it once transferred
         if (cmd.single_out || cmd.emit_step) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)                 rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> CW'(scan_ff) < count_ff)
      else $error("scan start outside table");

   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |-> s_ff < cnt_ff)
      else $error("batch emits more items than counted");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |=> rsp_valid_ff && rsp_ff.work_kind != KIND_NONE)
      else $error("work item not presented");

endmodule
